// ----- rtl/strb_pkg.sv -----
// ----------------------------------------------------------------------------
// strb_pkg
// Shared types and constants of the sequenced trace ring buffer: record
// layout, input and result items, controller states and action codes.
// ----------------------------------------------------------------------------
package strb_pkg;

  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned PAY_W   = 64;
  localparam int unsigned SEV_W   = 3;
  localparam int unsigned CORE_W  = 8;
  localparam int unsigned CNT_W   = 7;

  // Half of the sequence space; a record matches when (seq - start) is below it,
  // i.e. when the top bit of the 16-bit difference is clear.
  localparam logic [SEQ_W-1:0] SEQ_HALF = 16'h8000;

  // Action codes carried on the input tuser
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // One stored record (time, payload and the 27-bit meta word)
  typedef struct packed {
    logic [TIME_W-1:0] stamp_time;
    logic [PAY_W-1:0]  payload;
    logic [CORE_W-1:0] core_id;
    logic [SEV_W-1:0]  severity;
    logic [SEQ_W-1:0]  seq;
  } rec_t;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] stamp_time;
    logic [SEV_W-1:0]  severity;
    logic [CORE_W-1:0] core_id;
    logic [PAY_W-1:0]  payload;
    logic [SEQ_W-1:0]  from_seq;
    logic [CNT_W-1:0]  max_count;
  } in_item_t;

  typedef struct packed {
    logic              rec_valid;
    logic              last;
    logic [TIME_W-1:0] out_time;
    logic [SEV_W-1:0]  out_severity;
    logic [CORE_W-1:0] out_core;
    logic [SEQ_W-1:0]  out_seq;
    logic [PAY_W-1:0]  out_payload;
    logic [SEQ_W-1:0]  next_seq;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

endpackage

// ----- rtl/strb_ring_mem.sv -----
// ----------------------------------------------------------------------------
// strb_ring_mem
// Record store: one write port and one read port, read data registered
// and held while no read is issued.
// ----------------------------------------------------------------------------
module strb_ring_mem #(
  parameter int unsigned RING_DEPTH = 64,
  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  strb_pkg::rec_t wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output strb_pkg::rec_t rd_data_o
);
  import strb_pkg::*;

  rec_t mem_q [RING_DEPTH];
  rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/strb_ctrl.sv -----
// ----------------------------------------------------------------------------
// strb_ctrl
// Ring control: head, fill and sequence registers, store path, read walk
// with a one-record hold stage for the last flag, and the output register.
// ----------------------------------------------------------------------------
module strb_ctrl #(
  parameter int unsigned RING_DEPTH = 64,
  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  strb_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output strb_pkg::out_item_t  out_item_o,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output strb_pkg::rec_t       wr_data_o,
  output logic                 rd_en_o,
  output logic [AW-1:0]        rd_addr_o,
  input  strb_pkg::rec_t       rd_data_i
);
  import strb_pkg::*;

  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned OW = CW + 1;

  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [SEQ_W-1:0] start_q, start_d;
  logic [CNT_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0] nmatch_q, nmatch_d;
  logic [CW-1:0]    remain_q, remain_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic             s1_vld_q, s1_vld_d;
  rec_t             pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;
  out_item_t        out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic             out_free;
  logic             store_acc, read_acc;
  logic [OW-1:0]    old_sum;
  logic [AW-1:0]    oldest;
  logic [CNT_W-1:0] req_limit;
  logic [SEQ_W-1:0] seq_diff;
  logic             hit, stall, issue, walk_done;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign store_acc  = in_valid_i && in_ready_o && (in_item_i.action == ACT_STORE);
  assign read_acc   = in_valid_i && in_ready_o && (in_item_i.action == ACT_READ);

  // oldest = (head - fill) mod depth
  assign old_sum = OW'(head_q) + OW'(RING_DEPTH) - OW'(fill_q);
  assign oldest  = (old_sum >= OW'(RING_DEPTH)) ? AW'(old_sum - OW'(RING_DEPTH))
                                                : AW'(old_sum);

  assign req_limit = (in_item_i.max_count > CNT_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH)
                                                                : in_item_i.max_count;

  assign seq_diff = rd_data_i.seq - start_q;
  assign hit      = (state_q == ST_WALK) && s1_vld_q && ((seq_diff & SEQ_HALF) == '0)
                    && (nmatch_q < limit_q);
  // A new match needs the held record moved out first
  assign stall    = hit && pend_vld_q && !out_free;
  assign issue    = (state_q == ST_WALK) && (remain_q != '0) && (nmatch_q < limit_q)
                    && !stall;

  assign wr_en_o   = store_acc;
  assign wr_addr_o = head_q;
  assign wr_data_o = '{stamp_time: in_item_i.stamp_time, payload: in_item_i.payload,
                       core_id: in_item_i.core_id, severity: in_item_i.severity,
                       seq: seq_q};
  assign rd_en_o   = issue;
  assign rd_addr_o = addr_q;

  // Datapath next values
  always_comb begin
    head_d     = head_q;
    fill_d     = fill_q;
    seq_d      = seq_q;
    start_d    = start_q;
    limit_d    = limit_q;
    nmatch_d   = nmatch_q;
    remain_d   = remain_q;
    addr_d     = addr_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    s1_vld_d   = issue || (s1_vld_q && stall);

    if (store_acc) begin
      head_d = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + AW'(1);
      if (fill_q < CW'(RING_DEPTH)) begin
        fill_d = fill_q + CW'(1);
      end
      seq_d     = seq_q + SEQ_W'(1);
      out_vld_d = 1'b1;
      out_d     = '0;
      out_d.last     = 1'b1;
      out_d.out_seq  = seq_q;
      out_d.next_seq = seq_q + SEQ_W'(1);
    end

    if (read_acc) begin
      start_d    = in_item_i.from_seq;
      limit_d    = req_limit;
      nmatch_d   = '0;
      remain_d   = fill_q;
      addr_d     = oldest;
      pend_vld_d = 1'b0;
    end

    if (issue) begin
      addr_d   = (addr_q == AW'(RING_DEPTH - 1)) ? '0 : addr_q + AW'(1);
      remain_d = remain_q - CW'(1);
    end

    if (hit && !stall) begin
      if (pend_vld_q) begin
        out_vld_d = 1'b1;
        out_d     = '{rec_valid: 1'b1, last: 1'b0, out_time: pend_q.stamp_time,
                      out_severity: pend_q.severity, out_core: pend_q.core_id,
                      out_seq: pend_q.seq, out_payload: pend_q.payload,
                      next_seq: seq_q};
      end
      pend_d     = rd_data_i;
      pend_vld_d = 1'b1;
      nmatch_d   = nmatch_q + CNT_W'(1);
    end

    if ((state_q == ST_FLUSH) && out_free) begin
      out_vld_d = 1'b1;
      if (pend_vld_q) begin
        out_d = '{rec_valid: 1'b1, last: 1'b1, out_time: pend_q.stamp_time,
                  out_severity: pend_q.severity, out_core: pend_q.core_id,
                  out_seq: pend_q.seq, out_payload: pend_q.payload,
                  next_seq: seq_q};
      end else begin
        out_d          = '0;
        out_d.last     = 1'b1;
        out_d.next_seq = seq_q;
      end
      pend_vld_d = 1'b0;
    end

    // Drop any read still in flight once the walk is over
    if (state_d != ST_WALK) begin
      s1_vld_d = 1'b0;
    end
  end

  assign walk_done = (nmatch_d == limit_q) || ((remain_d == '0) && !issue
                     && !(s1_vld_q && stall));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (read_acc) begin
          state_d = ((req_limit == '0) || (fill_q == '0)) ? ST_FLUSH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      fill_q     <= '0;
      seq_q      <= '0;
      nmatch_q   <= '0;
      remain_q   <= '0;
      s1_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      fill_q     <= fill_d;
      seq_q      <= seq_d;
      nmatch_q   <= nmatch_d;
      remain_q   <= remain_d;
      s1_vld_q   <= s1_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    limit_q <= limit_d;
    addr_q  <= addr_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE) && !pend_vld_q && !s1_vld_q)
    else $error("input taken while a read walk is open");

  a_match_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (nmatch_q <= limit_q))
    else $error("more matches than the read limit");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> pend_vld_q && $stable(pend_q) && s1_vld_q)
    else $error("held record lost during output stall");

  a_issue_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> (remain_q != '0) && (state_q == ST_WALK))
    else $error("read issued past the stored records");

endmodule

// ----- rtl/sequenced_trace_ring_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// sequenced_trace_ring_buffer_unit
// Overwriting trace ring: stores sequence-stamped records and reads them
// back, oldest first, from a given sequence number onwards.
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata (low bit up)                                | tuser     | tlast
//  ----------+-----+---------------------------------------------------+-----------+-------
//  s_axis    | in  | stamp_time, severity, core_id, payload,           | action    | -
//            |     | from_seq, max_count (162 bits, padded to 168)     |           |
//  m_axis    | out | out_time, out_severity, out_core, out_seq,        | rec_valid | last
//            |     | out_payload, next_seq (171 bits, padded to 176)   |           |
//
//  A store can follow every cycle while m_axis drains.
//  A read visits the stored records (at most RING_DEPTH), oldest first; one
//  memory read port walks one entry per cycle while the walk is not stalled.
//  Reset clears head, fill count and sequence counter; the record memory is
//  not cleared, as only written entries are ever visited.
//  Back-pressure on m_axis stalls the walk in place; s_axis is held off
//  until every item of a read has been handed to the output register.
//
module sequenced_trace_ring_buffer_unit #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] stamp_time, [66:64] severity, [74:67] core_id, [138:75] payload,
  // [154:139] from_seq, [161:155] max_count, [167:162] zero
  input  logic [167:0] s_axis_tdata,
  // [0] action
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] out_time, [66:64] out_severity, [74:67] out_core, [90:75] out_seq,
  // [154:91] out_payload, [170:155] next_seq, [175:171] zero
  output logic [175:0] m_axis_tdata,
  // [0] rec_valid
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import strb_pkg::*;

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  in_item_t      in_item;
  out_item_t     out_item;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  rec_t          wr_data, rd_data;

  // Unpack the input item
  assign in_item.action     = s_axis_tuser;
  assign in_item.stamp_time = s_axis_tdata[63:0];
  assign in_item.severity   = s_axis_tdata[66:64];
  assign in_item.core_id    = s_axis_tdata[74:67];
  assign in_item.payload    = s_axis_tdata[138:75];
  assign in_item.from_seq   = s_axis_tdata[154:139];
  assign in_item.max_count  = s_axis_tdata[161:155];

  strb_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  strb_ring_mem #(
    .RING_DEPTH (RING_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Pack the result item
  assign m_axis_tdata = {5'b0, out_item.next_seq, out_item.out_payload, out_item.out_seq,
                         out_item.out_core, out_item.out_severity, out_item.out_time};
  assign m_axis_tuser = out_item.rec_valid;
  assign m_axis_tlast = out_item.last;

endmodule
